// ----- hdl/ddo_pkg.sv -----
`default_nettype none
package ddo_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int DVD_W        = 44;
  localparam int DVS_W        = 32;

  localparam logic [31:0] DPT_RESET  = 32'd1816353;
  localparam logic [31:0] TURN_RESET = 32'd1502342000;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic CFG_DPT  = 1'b0;
  localparam logic CFG_TURN = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUM, ST_DIFF, ST_TH_LO, ST_TH_HI, ST_TH_DONE,
    ST_CORD, ST_CMAG, ST_X_LO, ST_X_HI, ST_X_DONE,
    ST_Y_LO, ST_Y_HI, ST_Y_DONE, ST_RSTART, ST_RWAIT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RSEL_X, RSEL_Y, RSEL_TH
  } rsel_t;

  function automatic logic [31:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ddo_div.sv -----
`default_nettype none
module ddo_div
  import ddo_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  logic [DVS_W-1:0]       rem;
  logic [DVD_W-1:0]       dvd;
  logic [DVS_W-1:0]       dvs;
  logic [$clog2(DVD_W):0] cnt;
  logic                   busy;
  logic [DVS_W:0]         trial;
  logic                   fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 1;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
      cnt <= ($clog2(DVD_W)+1)'(DVD_W);
    end else if (busy) begin
      rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      dvd      <= {dvd[DVD_W-2:0], 1'b0};
      quotient <= {quotient[DVD_W-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/differential_drive_odometry.sv -----
`default_nettype none
// Differential-drive wheel odometry. Each item carries signed left/right tick counts and a
// millisecond stamp; the block integrates pose (x, y in Q16.16 m, binary-angle heading) and
// returns one result with pose, velocities and turn rate. One 32x32 multiplier, a 24-step
// CORDIC and a 44-step restoring divider are used in turn, one item at a time; the three
// velocity divisions are skipped when the elapsed time is zero. A new item is taken as
// soon as the previous one has been loaded into the output register. The user must write
// configuration only while idle; the block itself does not enforce this.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,   // left_ticks, right_ticks, stamp_ms
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [175:0]      m_tdata,   // pos_x, pos_y, heading, speed_x, speed_y, turn_rate
  output logic [0:0]        m_tuser,   // rate_invalid
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  state_t state, state_next;

  logic [31:0] dpt, turn;
  logic [31:0] pose_x, pose_y, last_stamp, elapsed;
  logic [ANGLE_BITS-1:0] pose_heading, head_new;

  logic        sum_neg, diff_neg;
  logic [16:0] sum_abs, diff_abs;
  logic [48:0] sum_mag;
  logic [47:0] diff_mag;
  logic [31:0] dth_mag;
  logic [81:0] acc;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        acc_load, acc_add;

  logic signed [33:0] cx, cy, cz, zinit, cx_sh, cy_sh, cv, sv;
  logic [CNT_W-1:0]   cnt;
  logic               flip;
  logic [31:0]        ang;
  logic [31:0]        cmag, smag;
  logic               cneg, sneg;

  logic [33:0] dx_mag, dy_mag, r_mag;
  logic        dx_neg, dy_neg, r_neg;
  logic [31:0] dx32, dy32;
  rsel_t       rsel;
  logic        div_start, div_done;
  logic [DVD_W-1:0] quo;
  logic [31:0] sat;
  logic [31:0] spd_x, spd_y, trate;
  logic        rinv;

  logic signed [16:0] sum_w, diff_w;
  logic [ANGLE_BITS+15:0] hwide;

  assign s_tready = state == ST_IDLE;
  assign prod     = {32'b0, mul_a} * {32'b0, mul_b};
  assign sum_w    = $signed({s_tdata[15], s_tdata[15:0]}) + $signed({s_tdata[31], s_tdata[31:16]});
  assign diff_w   = $signed({s_tdata[15], s_tdata[15:0]}) - $signed({s_tdata[31], s_tdata[31:16]});

  always_comb begin
    head_new = pose_heading + (diff_neg ? ANGLE_BITS'(-acc[48 +: ANGLE_BITS])
                                        : acc[48 +: ANGLE_BITS]);
    ang      = {head_new, (32-ANGLE_BITS)'(0)};
    zinit    = 34'(signed'(ang));
    cx_sh    = cx >>> cnt;
    cy_sh    = cy >>> cnt;
    cv       = flip ? -cx : cx;
    sv       = flip ? -cy : cy;
    dx32     = (sum_neg ^ cneg) ? -acc[78:47] : acc[78:47];
    dy32     = (sum_neg ^ sneg) ? -acc[78:47] : acc[78:47];
    case (rsel)
      RSEL_X:  begin r_mag = dx_mag;          r_neg = dx_neg;   end
      RSEL_Y:  begin r_mag = dy_mag;          r_neg = dy_neg;   end
      default: begin r_mag = {2'b0, dth_mag}; r_neg = diff_neg; end
    endcase
    if (r_neg) begin
      sat = (quo >= DVD_W'(33'h080000000)) ? 32'h80000000 : -quo[31:0];
    end else begin
      sat = (quo > DVD_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo[31:0];
    end
    hwide = {pose_heading, 16'b0};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_SUM;
      ST_SUM:     state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_TH_LO;
      ST_TH_LO:   state_next = ST_TH_HI;
      ST_TH_HI:   state_next = ST_TH_DONE;
      ST_TH_DONE: state_next = ST_CORD;
      ST_CORD:    if (cnt == CNT_W'(CORDIC_STEPS-1)) state_next = ST_CMAG;
      ST_CMAG:    state_next = ST_X_LO;
      ST_X_LO:    state_next = ST_X_HI;
      ST_X_HI:    state_next = ST_X_DONE;
      ST_X_DONE:  state_next = ST_Y_LO;
      ST_Y_LO:    state_next = ST_Y_HI;
      ST_Y_HI:    state_next = ST_Y_DONE;
      ST_Y_DONE:  state_next = (elapsed == '0) ? ST_DONE : ST_RSTART;
      ST_RSTART:  state_next = ST_RWAIT;
      ST_RWAIT: begin
        if (div_done) state_next = (rsel == RSEL_TH) ? ST_DONE : ST_RSTART;
      end
      ST_DONE:    if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and unit controls
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    acc_load  = 1'b0;
    acc_add   = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_SUM:    begin mul_a = 32'(sum_abs);  mul_b = dpt; end
      ST_DIFF:   begin mul_a = 32'(diff_abs); mul_b = dpt; end
      ST_TH_LO:  begin mul_a = diff_mag[31:0]; mul_b = turn; acc_load = 1'b1; end
      ST_TH_HI:  begin mul_a = 32'(diff_mag[47:32]); mul_b = turn; acc_add = 1'b1; end
      ST_X_LO:   begin mul_a = sum_mag[31:0]; mul_b = cmag; acc_load = 1'b1; end
      ST_X_HI:   begin mul_a = 32'(sum_mag[48:32]); mul_b = cmag; acc_add = 1'b1; end
      ST_Y_LO:   begin mul_a = sum_mag[31:0]; mul_b = smag; acc_load = 1'b1; end
      ST_Y_HI:   begin mul_a = 32'(sum_mag[48:32]); mul_b = smag; acc_add = 1'b1; end
      ST_RSTART: div_start = 1'b1;
      default:   ;
    endcase
  end

  ddo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DVD_W'(r_mag) * DVD_W'(1000)),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dpt          <= DPT_RESET;
      turn         <= TURN_RESET;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      last_stamp   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DPT:  dpt  <= cfg_data;
          CFG_TURN: turn <= cfg_data;
          default:  ;
        endcase
      end
      if (state == ST_IDLE && s_tvalid) last_stamp <= s_tdata[63:32];
      if (state == ST_TH_DONE) pose_heading <= head_new;
      if (state == ST_X_DONE) pose_x <= pose_x + dx32;
      if (state == ST_Y_DONE) pose_y <= pose_y + dy32;
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_load) acc <= 82'(prod);
    if (acc_add)  acc <= acc + (82'(prod) << 32);
    case (state)
      ST_IDLE: begin
        sum_neg  <= sum_w[16];
        diff_neg <= diff_w[16];
        sum_abs  <= sum_w[16] ? 17'(-sum_w) : 17'(sum_w);
        diff_abs <= diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
        elapsed  <= s_tdata[63:32] - last_stamp;
      end
      ST_SUM:  sum_mag  <= prod[48:0];
      ST_DIFF: diff_mag <= prod[47:0];
      ST_TH_DONE: begin
        dth_mag <= acc[79:48];
        cx      <= CORDIC_X0;
        cy      <= '0;
        cnt     <= '0;
        // fold into the right half-plane
        if (zinit > 34'sd1073741824) begin
          cz <= zinit - 34'sd2147483648; flip <= 1'b1;
        end else if (zinit < -34'sd1073741824) begin
          cz <= zinit + 34'sd2147483648; flip <= 1'b1;
        end else begin
          cz <= zinit; flip <= 1'b0;
        end
      end
      ST_CORD: begin
        cnt <= cnt + 1'b1;
        if (!cz[33]) begin
          cx <= cx - cy_sh; cy <= cy + cx_sh; cz <= cz - 34'(atan_lut(cnt));
        end else begin
          cx <= cx + cy_sh; cy <= cy - cx_sh; cz <= cz + 34'(atan_lut(cnt));
        end
      end
      ST_CMAG: begin
        cneg <= cv[33];
        sneg <= sv[33];
        cmag <= cv[33] ? 32'(-cv) : cv[31:0];
        smag <= sv[33] ? 32'(-sv) : sv[31:0];
      end
      ST_X_DONE: begin
        dx_mag <= acc[80:47];
        dx_neg <= sum_neg ^ cneg;
      end
      ST_Y_DONE: begin
        dy_mag <= acc[80:47];
        dy_neg <= sum_neg ^ sneg;
        rsel   <= RSEL_X;
        rinv   <= elapsed == '0;
        spd_x  <= '0;
        spd_y  <= '0;
        trate  <= '0;
      end
      ST_RWAIT: begin
        if (div_done) begin
          case (rsel)
            RSEL_X:  begin spd_x <= sat; rsel <= RSEL_Y;  end
            RSEL_Y:  begin spd_y <= sat; rsel <= RSEL_TH; end
            default: trate <= sat;
          endcase
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {trate, spd_y, spd_x, hwide[ANGLE_BITS+15 -: 16], pose_y, pose_x};
          m_tuser <= rinv;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted item while busy");

  a_zero_rates: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[175:80] == '0)
    else $error("rates not zero on invalid elapsed time");

  a_skip_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_Y_DONE && elapsed == '0 |=> state == ST_DONE)
    else $error("division started with zero elapsed time");
`endif

endmodule
`default_nettype wire
